// ----- rtl/core/strict_priority_multi_fifo_defines.svh -----
// assertion macros for the strict priority multi fifo
// used by the top level; expects a clock named clk and a reset named rst
`ifndef STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH
`define STRICT_PRIORITY_MULTI_FIFO_DEFINES_SVH

// same-cycle implication, off during reset
`define SPMF_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off during reset
`define SPMF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/spmf_pkg.sv -----
// shared types and constants for the strict priority multi fifo
// no dependencies
`default_nettype none

package spmf_pkg;

  localparam int LEVELS_DEF      = 5;
  localparam int LEVEL_DEPTH_DEF = 16;

  localparam int LEVEL_W  = 3;
  localparam int TAG_W    = 16;
  localparam int STATUS_W = 2;
  localparam int MASK_W   = 5;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_SERVE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_EMPTY     = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_BAD_LEVEL = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_RESULT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic exec;
  } ctrl_cmd_t;

endpackage

`default_nettype wire

// ----- rtl/core/strict_priority_multi_fifo.sv -----
// top level of the strict priority multi fifo
// depends on spmf_pkg, spmf_ctrl, spmf_datapath and the defines header
//
// usage:
//   a request (operation, level, patient_tag) is taken at a rising edge with
//   start high and busy low. operation add appends patient_tag to the fifo of
//   its level; operation serve pops the head of the most urgent non-empty
//   level (level 1 first).
//   every transaction gives one result: status, served_tag, served_level and
//   nonempty_mask, valid for exactly one cycle while done is high.
//   done is high in the result state, which follows the exec state that the
//   accepting edge enters; the three-state sequencer (capture, queue update with
//   tag memory access, result) takes no new transaction until the result is out.
//   busy is high from the accepting edge until the result cycle ends.
//   the receiver cannot stall; results are not held.
//   reset empties every level at once (counts and pointers cleared); the tag
//   memory is not cleared and needs no clearing pass.
`default_nettype none

module strict_priority_multi_fifo #(
  parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation,
  input  logic [spmf_pkg::LEVEL_W-1:0]  level,
  input  logic [spmf_pkg::TAG_W-1:0]    patient_tag,
  output logic                          done,
  output logic [spmf_pkg::STATUS_W-1:0] status,
  output logic [spmf_pkg::TAG_W-1:0]    served_tag,
  output logic [spmf_pkg::LEVEL_W-1:0]  served_level,
  output logic [spmf_pkg::MASK_W-1:0]   nonempty_mask
);
  import spmf_pkg::*;

  `include "strict_priority_multi_fifo_defines.svh"

  ctrl_cmd_t cmd;

  spmf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  spmf_datapath #(
    .LEVELS      (LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .operation     (operation),
    .level         (level),
    .patient_tag   (patient_tag),
    .status        (status),
    .served_tag    (served_tag),
    .served_level  (served_level),
    .nonempty_mask (nonempty_mask)
  );

  `SPMF_ASSERT_NEXT(a_accept_busy, start && !busy, busy && !done, "accepted transaction not busy")
  `SPMF_ASSERT_NEXT(a_single_done, done, !done && !busy, "result strobe longer than one cycle")
  `SPMF_ASSERT_NOW(a_no_serve_clean, done && status != STATUS_OK, served_tag == '0 && served_level == '0, "failed transaction reports a served entry")
  `SPMF_ASSERT_NOW(a_served_level_ok, done && served_level != '0, status == STATUS_OK, "served level with bad status")

endmodule

`default_nettype wire

// ----- rtl/core/spmf_ctrl.sv -----
// sequencing state machine for the strict priority multi fifo
// depends on spmf_pkg
`default_nettype none

module spmf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  output logic               done,
  output spmf_pkg::ctrl_cmd_t cmd
);
  import spmf_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        done       = 1'b1;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- rtl/core/spmf_datapath.sv -----
// queue pointers, counts, tag memory and result registers
// depends on spmf_pkg; driven by spmf_ctrl commands
`default_nettype none

module spmf_datapath #(
  parameter int LEVELS      = spmf_pkg::LEVELS_DEF,
  parameter int LEVEL_DEPTH = spmf_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  spmf_pkg::ctrl_cmd_t              cmd,
  input  logic                             operation,
  input  logic [spmf_pkg::LEVEL_W-1:0]     level,
  input  logic [spmf_pkg::TAG_W-1:0]       patient_tag,
  output logic [spmf_pkg::STATUS_W-1:0]    status,
  output logic [spmf_pkg::TAG_W-1:0]       served_tag,
  output logic [spmf_pkg::LEVEL_W-1:0]     served_level,
  output logic [spmf_pkg::MASK_W-1:0]      nonempty_mask
);
  import spmf_pkg::*;

  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int SW    = $clog2(LEVEL_DEPTH);
  localparam int CW    = $clog2(LEVEL_DEPTH + 1);
  localparam int WORDS = LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(WORDS);

  // captured request
  logic               op_q;
  logic [LEVEL_W-1:0] lvl_q;
  logic [TAG_W-1:0]   tag_q;

  logic [SW-1:0] head  [LEVELS];
  logic [SW-1:0] tail  [LEVELS];
  logic [CW-1:0] count [LEVELS];

  logic [TAG_W-1:0] mem [WORDS];
  logic [TAG_W-1:0] rd_data;

  logic [STATUS_W-1:0] status_q;
  logic [LEVEL_W-1:0]  slvl_q;
  logic                hit_q;

  logic               lvl_ok;
  logic [LEVEL_W-1:0] lvl_m1;
  logic [LW-1:0]      q_add;
  logic               full;
  logic               found;
  logic [LW-1:0]      pick;
  logic               wr_en;
  logic               rd_en;
  logic [LW-1:0]      q_sel;
  logic [SW-1:0]      slot_sel;
  logic [AW-1:0]      addr;
  logic [LW:0]        pick_p1;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == SW'(LEVEL_DEPTH - 1)) ? '0 : s + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_q  <= operation;
      lvl_q <= level;
      tag_q <= patient_tag;
    end
  end

  assign lvl_ok = (lvl_q != '0) && (32'(lvl_q) <= LEVELS);
  assign lvl_m1 = lvl_q - 1'b1;
  assign q_add  = LW'(lvl_m1);
  assign full   = (count[q_add] == CW'(LEVEL_DEPTH));

  // strict priority pick, lowest index wins
  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = LEVELS - 1; i >= 0; i--) begin
      if (count[i] != '0) begin
        found = 1'b1;
        pick  = LW'(i);
      end
    end
  end

  assign wr_en    = cmd.exec && (op_q == OP_ADD) && lvl_ok && !full;
  assign rd_en    = cmd.exec && (op_q == OP_SERVE) && found;
  assign q_sel    = (op_q == OP_ADD) ? q_add : pick;
  assign slot_sel = (op_q == OP_ADD) ? tail[q_sel] : head[q_sel];
  assign addr     = AW'(AW'(q_sel) * AW'(LEVEL_DEPTH)) + AW'(slot_sel);
  assign pick_p1  = {1'b0, pick} + 1'b1;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= tag_q;
    end
    if (rd_en) begin
      rd_data <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else begin
      if (wr_en) begin
        tail[q_sel]  <= next_slot(tail[q_sel]);
        count[q_sel] <= count[q_sel] + 1'b1;
      end
      if (rd_en) begin
        head[q_sel]  <= next_slot(head[q_sel]);
        count[q_sel] <= count[q_sel] - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      hit_q  <= rd_en;
      slvl_q <= rd_en ? LEVEL_W'(pick_p1) : '0;
      if (op_q == OP_SERVE) begin
        status_q <= found ? STATUS_OK : STATUS_EMPTY;
      end else if (!lvl_ok) begin
        status_q <= STATUS_BAD_LEVEL;
      end else if (full) begin
        status_q <= STATUS_FULL;
      end else begin
        status_q <= STATUS_OK;
      end
    end
  end

  assign status       = status_q;
  assign served_level = slvl_q;
  assign served_tag   = hit_q ? rd_data : '0;

  // counts are already updated when the result is shown
  for (genvar g = 0; g < MASK_W; g++) begin : g_mask
    if (g < LEVELS) begin : g_live
      assign nonempty_mask[g] = (count[g] != '0);
    end else begin : g_none
      assign nonempty_mask[g] = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- test/strict_priority_multi_fifo_test.sv -----
// self-checking testbench for strict_priority_multi_fifo: directed table, then random traffic
// keeps its own per-level queue model; depends on spmf_pkg and the rtl top level
`default_nettype none

module strict_priority_multi_fifo_test;
  import spmf_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_ITEMS = 500;
  localparam int NUM_PHASES  = 4;
  localparam int SETTLE_CYCLES = 8;

  localparam int REGIME_FILL  = 0;
  localparam int REGIME_DRAIN = 1;
  localparam int REGIME_MIXED = 2;

  typedef struct packed {
    status_t             status;
    logic [TAG_W-1:0]    served_tag;
    logic [LEVEL_W-1:0]  served_lvl;
    logic [MASK_W-1:0]   mask;
  } outcome_t;

  typedef struct {
    op_t                op;
    logic [LEVEL_W-1:0] lvl;
    logic [TAG_W-1:0]   tag;
    int unsigned        reps;
    logic               fixed;
    outcome_t           want;
  } request_row_t;

  // fixed rows hold a typed-in result, the rest go through the queue model
  request_row_t directed_rows [12] = '{
    '{OP_SERVE, 3'd0, 16'h0000, 1, 1'b1, '{STATUS_EMPTY, 16'h0, 3'd0, 5'b00000}},
    '{OP_ADD,   3'd0, 16'hffff, 1, 1'b1, '{STATUS_BAD_LEVEL, 16'h0, 3'd0, 5'b00000}},
    '{OP_ADD,   3'd6, 16'h0000, 1, 1'b1, '{STATUS_BAD_LEVEL, 16'h0, 3'd0, 5'b00000}},
    '{OP_ADD,   3'd7, 16'haaaa, 1, 1'b1, '{STATUS_BAD_LEVEL, 16'h0, 3'd0, 5'b00000}},
    '{OP_ADD,   3'd5, 16'hffff, 1, 1'b1, '{STATUS_OK, 16'h0, 3'd0, 5'b10000}},
    '{OP_ADD,   3'd1, 16'h0000, 1, 1'b1, '{STATUS_OK, 16'h0, 3'd0, 5'b10001}},
    '{OP_ADD,   3'd3, 16'h5555, 1, 1'b0, '{STATUS_OK, 16'h0, 3'd0, 5'b00000}},
    '{OP_ADD,   3'd2, 16'haaaa, 1, 1'b0, '{STATUS_OK, 16'h0, 3'd0, 5'b00000}},
    '{OP_SERVE, 3'd7, 16'hffff, 1, 1'b1, '{STATUS_OK, 16'h0000, 3'd1, 5'b10110}},
    '{OP_SERVE, 3'd2, 16'h1234, 3, 1'b0, '{STATUS_OK, 16'h0, 3'd0, 5'b00000}},
    '{OP_ADD,   3'd4, 16'h8000, 16, 1'b0, '{STATUS_OK, 16'h0, 3'd0, 5'b00000}},
    '{OP_ADD,   3'd4, 16'h7fff, 1, 1'b1, '{STATUS_FULL, 16'h0, 3'd0, 5'b01000}}
  };

  logic clk = 1'b0;
  logic rst;
  logic start;
  logic busy;
  logic operation;
  logic [LEVEL_W-1:0]  level;
  logic [TAG_W-1:0]    patient_tag;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    served_tag;
  logic [LEVEL_W-1:0]  served_level;
  logic [MASK_W-1:0]   nonempty_mask;

  // queue model state
  logic [TAG_W-1:0] tag_mem [LEVELS_DEF][LEVEL_DEPTH_DEF];
  int unsigned head_ptr   [LEVELS_DEF];
  int unsigned tail_ptr   [LEVELS_DEF];
  int unsigned fill_count [LEVELS_DEF];

  outcome_t pending_results [$];
  int fail_count = 0;
  int sender_idle_pct = 0;
  int unsigned cycle_count = 0;

  strict_priority_multi_fifo u_dut (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .operation     (operation),
    .level         (level),
    .patient_tag   (patient_tag),
    .done          (done),
    .status        (status),
    .served_tag    (served_tag),
    .served_level  (served_level),
    .nonempty_mask (nonempty_mask)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic outcome_t apply_request(input op_t op, input logic [LEVEL_W-1:0] lvl,
                                             input logic [TAG_W-1:0] tag);
    outcome_t r;
    int q;
    logic served;
    r.status     = STATUS_OK;
    r.served_tag = '0;
    r.served_lvl = '0;
    r.mask       = '0;
    served = 1'b0;
    if (op == OP_ADD) begin
      if (lvl == 0 || lvl > LEVELS_DEF) begin
        r.status = STATUS_BAD_LEVEL;
      end else if (fill_count[lvl-1] >= LEVEL_DEPTH_DEF) begin
        r.status = STATUS_FULL;
      end else begin
        q = lvl - 1;
        tag_mem[q][tail_ptr[q]] = tag;
        tail_ptr[q] = (tail_ptr[q] + 1) % LEVEL_DEPTH_DEF;
        fill_count[q]++;
      end
    end else begin
      // lowest-numbered non-empty level wins
      for (q = 0; q < LEVELS_DEF; q++) begin
        if (!served && fill_count[q] != 0) begin
          r.served_tag = tag_mem[q][head_ptr[q]];
          r.served_lvl = LEVEL_W'(q + 1);
          head_ptr[q] = (head_ptr[q] + 1) % LEVEL_DEPTH_DEF;
          fill_count[q]--;
          served = 1'b1;
        end
      end
      if (!served) r.status = STATUS_EMPTY;
    end
    for (q = 0; q < LEVELS_DEF && q < MASK_W; q++) begin
      if (fill_count[q] != 0) r.mask[q] = 1'b1;
    end
    return r;
  endfunction

  // called at a falling edge; returns at a falling edge with start possibly still high
  task automatic issue_request(input op_t op, input logic [LEVEL_W-1:0] lvl,
                               input logic [TAG_W-1:0] tag, input logic fixed,
                               input outcome_t want);
    outcome_t predicted;
    start       <= 1'b1;
    operation   <= op;
    level       <= lvl;
    patient_tag <= tag;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(op, lvl, tag);
    pending_results.push_back(fixed ? want : predicted);
    @(negedge clk);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
    end
  endtask

  task automatic wait_for_results();
    start <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $error("result with no transaction outstanding");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status);
          fail_count++;
        end
        if (served_tag !== want.served_tag) begin
          $error("served_tag: expected %h, got %h", want.served_tag, served_tag);
          fail_count++;
        end
        if (served_level !== want.served_lvl) begin
          $error("served_level: expected %0d, got %0d", want.served_lvl, served_level);
          fail_count++;
        end
        if (nonempty_mask !== want.mask) begin
          $error("nonempty_mask: expected %b, got %b", want.mask, nonempty_mask);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("strict_priority_multi_fifo_test NOT OK");
      $finish;
    end
  end

  initial begin
    int phase_idle_pct [NUM_PHASES];
    int unsigned k;
    int phase;
    int counted;
    int burst_left;
    int regime;
    int roll;
    int pick;
    logic do_add;
    logic [LEVEL_W-1:0] hot_level;
    logic [LEVEL_W-1:0] lvl;
    logic [TAG_W-1:0] tag;
    op_t op;

    phase_idle_pct = '{0, 63, 28, 0};
    rst         = 1'b1;
    start       = 1'b0;
    operation   = 1'b0;
    level       = '0;
    patient_tag = '0;
    for (int q = 0; q < LEVELS_DEF; q++) begin
      head_ptr[q]   = 0;
      tail_ptr[q]   = 0;
      fill_count[q] = 0;
    end

    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[i]) begin
      for (k = 0; k < directed_rows[i].reps; k++) begin
        issue_request(directed_rows[i].op, directed_rows[i].lvl,
                      TAG_W'(directed_rows[i].tag + k), directed_rows[i].fixed,
                      directed_rows[i].want);
      end
    end
    wait_for_results();

    for (phase = 0; phase < NUM_PHASES; phase++) begin
      sender_idle_pct = phase_idle_pct[phase];
      counted    = 0;
      burst_left = 0;
      regime     = REGIME_MIXED;
      hot_level  = 3'd1;
      while (counted < PHASE_ITEMS) begin
        // bursts that favor one level build queues up to full, drain bursts empty them
        if (burst_left == 0) begin
          regime     = $urandom_range(REGIME_MIXED);
          hot_level  = LEVEL_W'($urandom_range(LEVELS_DEF, 1));
          burst_left = $urandom_range(48, 8);
        end
        burst_left--;
        roll = $urandom_range(99);
        tag  = TAG_W'($urandom);
        if (roll < 5) begin
          pick = $urandom_range(2);
          op   = OP_ADD;
          lvl  = (pick == 0) ? LEVEL_W'(0) : LEVEL_W'(LEVELS_DEF + pick);
        end else begin
          case (regime)
            REGIME_FILL:  do_add = (roll < 80);
            REGIME_DRAIN: do_add = (roll >= 80);
            default:      do_add = (roll < 52);
          endcase
          if (do_add) begin
            op  = OP_ADD;
            lvl = $urandom_range(1) ? hot_level : LEVEL_W'($urandom_range(LEVELS_DEF, 1));
          end else begin
            op  = OP_SERVE;
            lvl = LEVEL_W'($urandom_range(7));
          end
          counted++;
        end
        issue_request(op, lvl, tag, 1'b0, '0);
      end
      // hold off until every transaction of the phase has come back
      wait_for_results();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("strict_priority_multi_fifo_test OK");
    end else begin
      $display("strict_priority_multi_fifo_test NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
